[hdl/pffl_pkg.sv]
// shared constants, codes and types for the page frame free list
package pffl_pkg;

  localparam int FRAMES     = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int ADDR_W     = 24;
  localparam int COUNT_W    = 13;
  localparam int LIMIT_W    = 13;
  localparam int LINK_W     = FRAME_W + 1;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // register index codes
  localparam logic REG_FRAME_LIMIT = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic push;     // free in range: link and push frame
    logic reject;   // free out of range
    logic empty;    // allocate on empty list
    logic read;     // allocate: read link of current head
    logic pop;      // allocate: link data back, commit pop
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic head_valid;
    logic in_range;
  } dp_status_t;

endpackage

[hdl/page_frame_free_list_top.sv]
// top level of the page frame free list allocator
// results: a free or an allocate on an empty list gives its result in the cycle
//   after acceptance; a successful allocate reads the link of the current head
//   from the registered link memory, then pops in ST_READ and registers its result
// throughput: one free per cycle when not busy; no item is taken during ST_READ
// reset: list empty, free count and frame limit zero; link memory not cleared
module page_frame_free_list_top import pffl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action,
  input  logic [ADDR_W-1:0]     frame_addr,
  output logic                  done,
  output logic [ADDR_W-1:0]     granted_addr,
  output logic                  failed,
  output logic [COUNT_W-1:0]    free_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic               cfg_we;
  logic [LIMIT_W-1:0] frame_limit;
  logic               reg_sel;

  // register decode
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1] == REG_FRAME_LIMIT;
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? APB_DATA_W'(frame_limit) : '0;

  pffl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  pffl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .frame_addr   (frame_addr),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[LIMIT_W-1:0]),
    .frame_limit  (frame_limit),
    .done         (done),
    .granted_addr (granted_addr),
    .failed       (failed),
    .free_count   (free_count)
  );

endmodule

[hdl/pffl_ram.sv]
// generic single-write, single-read ram with registered read data
module pffl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/pffl_ctrl.sv]
// controller state machine: accepts items and sequences the pop read
module pffl_ctrl import pffl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       action,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (action == ACT_ALLOC) && status.head_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_FREE) begin
            cmd.push   = status.in_range;
            cmd.reject = !status.in_range;
          end else begin
            cmd.read  = status.head_valid;
            cmd.empty = !status.head_valid;
          end
        end
      end
      ST_READ: begin
        busy    = 1'b1;
        cmd.pop = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

[hdl/pffl_dp.sv]
// datapath: head register, free count, link memory, limit register, result
module pffl_dp import pffl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic [ADDR_W-1:0]     frame_addr,
  input  logic                  cfg_we,
  input  logic [LIMIT_W-1:0]    cfg_wdata,
  output logic [LIMIT_W-1:0]    frame_limit,
  output logic                  done,
  output logic [ADDR_W-1:0]     granted_addr,
  output logic                  failed,
  output logic [COUNT_W-1:0]    free_count
);

  logic               head_valid;
  logic [FRAME_W-1:0] head_frame;
  logic [COUNT_W-1:0] free_total;
  logic [FRAME_W-1:0] in_frame;
  logic [LINK_W-1:0]  link_rdata;
  logic [LINK_W-1:0]  link_wdata;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] count_dec;

  // frame index of the item: offset bits dropped
  assign in_frame = frame_addr[PAGE_SHIFT +: FRAME_W];

  assign status.head_valid = head_valid;
  assign status.in_range   = {1'b0, in_frame} < frame_limit;

  // link entry of a pushed frame names the old head
  assign link_wdata = {head_valid, head_frame};

  // saturating count steps
  assign count_inc = (free_total < COUNT_W'(FRAMES)) ? free_total + COUNT_W'(1) : free_total;
  assign count_dec = (free_total != '0) ? free_total - COUNT_W'(1) : free_total;

  pffl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (FRAMES)
  ) u_link_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (in_frame),
    .wdata (link_wdata),
    .re    (cmd.read),
    .raddr (head_frame),
    .rdata (link_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= '0;
    end else if (cfg_we) begin
      frame_limit <= cfg_wdata;
    end
  end

  // list head and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      head_frame <= '0;
      free_total <= '0;
    end else if (cmd.push) begin
      head_valid <= 1'b1;
      head_frame <= in_frame;
      free_total <= count_inc;
    end else if (cmd.pop) begin
      head_valid <= link_rdata[LINK_W-1];
      head_frame <= link_rdata[FRAME_W-1:0];
      free_total <= count_dec;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.push || cmd.reject || cmd.empty || cmd.pop;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      granted_addr <= '0;
      failed       <= 1'b0;
      free_count   <= count_inc;
    end else if (cmd.pop) begin
      granted_addr <= {head_frame, {PAGE_SHIFT{1'b0}}};
      failed       <= 1'b0;
      free_count   <= count_dec;
    end else if (cmd.reject || cmd.empty) begin
      granted_addr <= '0;
      failed       <= 1'b1;
      free_count   <= free_total;
    end
  end

endmodule

[dv/tb_page_frame_free_list_top.sv]
// testbench for the page frame free list allocator: directed and random items
module tb_page_frame_free_list_top;
  import pffl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one request as the driver presents it
  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] frame_addr;
  } frame_req_t;

  // one result as the block should report it
  typedef struct packed {
    logic [ADDR_W-1:0]  granted_addr;
    logic               failed;
    logic [COUNT_W-1:0] free_count;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  action = ACT_ALLOC;
  logic [ADDR_W-1:0]     frame_addr = '0;
  logic                  done;
  logic [ADDR_W-1:0]     granted_addr;
  logic                  failed;
  logic [COUNT_W-1:0]    free_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  page_frame_free_list_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .frame_addr(frame_addr),
    .done(done), .granted_addr(granted_addr), .failed(failed), .free_count(free_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predicted allocator state
  logic [FRAME_W-1:0] link_next  [FRAMES];
  logic               link_valid [FRAMES];
  logic               top_valid = 1'b0;
  logic [FRAME_W-1:0] top_frame = '0;
  logic [COUNT_W-1:0] free_cnt = '0;
  logic [LIMIT_W-1:0] limit_reg = '0;

  // stimulus side view of the list, used to avoid double frees
  int unsigned gen_stack[$];
  bit          gen_on [FRAMES];
  int unsigned gen_lim = 0;

  frame_req_t    pending_items[$];
  frame_result_t expected_results[$];
  frame_req_t    drv_item;
  int            gap_left = 0;
  int            no_idle_left = 0;
  int            errors = 0;

  // apply one item to the predicted state and return its result
  function automatic frame_result_t step_allocator(logic act, logic [ADDR_W-1:0] addr);
    frame_result_t      res;
    logic [FRAME_W-1:0] idx;
    logic               nxt_valid;
    res.granted_addr = '0;
    res.failed = 1'b0;
    // a 24-bit address always yields an index below the frame count
    idx = addr[PAGE_SHIFT +: FRAME_W];
    if (act == ACT_FREE) begin
      if ({1'b0, idx} >= limit_reg) begin
        res.failed = 1'b1;
      end else begin
        link_next[idx]  = top_frame;
        link_valid[idx] = top_valid;
        top_frame = idx;
        top_valid = 1'b1;
        if (free_cnt < COUNT_W'(FRAMES)) free_cnt++;
      end
    end else if (!top_valid) begin
      res.failed = 1'b1;
    end else begin
      res.granted_addr = ADDR_W'(top_frame) << PAGE_SHIFT;
      nxt_valid = link_valid[top_frame];
      top_frame = link_next[top_frame];
      top_valid = nxt_valid;
      if (free_cnt != '0) free_cnt--;
    end
    res.free_count = free_cnt;
    return res;
  endfunction

  function automatic int unsigned eff_limit();
    return (gen_lim > FRAMES) ? FRAMES : gen_lim;
  endfunction

  // byte address of a frame with a random offset
  function automatic logic [ADDR_W-1:0] frame_address(int unsigned idx);
    return (ADDR_W'(idx) << PAGE_SHIFT) | ADDR_W'($urandom_range(0, (1 << PAGE_SHIFT) - 1));
  endfunction

  // queue an item and track what it does to the list
  function automatic void add_item(logic act, logic [ADDR_W-1:0] addr);
    int unsigned idx;
    pending_items.push_back('{act, addr});
    idx = 32'(addr >> PAGE_SHIFT);
    if (act == ACT_FREE) begin
      if (idx < eff_limit()) begin
        gen_stack.push_back(idx);
        gen_on[idx] = 1'b1;
      end
    end else if (gen_stack.size() > 0) begin
      idx = gen_stack.pop_back();
      gen_on[idx] = 1'b0;
    end
  endfunction

  // in-range frame to free, or -1 when none found
  function automatic int pick_free_frame(bit allow_dup);
    int unsigned idx;
    if (eff_limit() == 0) return -1;
    repeat (8) begin
      idx = $urandom_range(0, eff_limit() - 1);
      if (allow_dup || !gen_on[idx]) return idx;
    end
    return -1;
  endfunction

  // idle cycles after an item: mostly none, a few long, some stretches without any
  function automatic int pick_gap();
    int r;
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) no_idle_left = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // bursts of frees or allocates with some out-of-range and empty-list noise
  task automatic gen_random(int n, bit allow_dup);
    int made;
    int burst;
    int idx;
    int r;
    bit fill;
    made = 0;
    while (made < n) begin
      fill  = 1'($urandom_range(0, 1));
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 10 && eff_limit() < FRAMES) begin
          idx = $urandom_range(eff_limit(), FRAMES - 1);
          add_item(ACT_FREE, frame_address(idx));
        end else if ((fill && r < 85) || (!fill && r < 25)) begin
          idx = pick_free_frame(allow_dup);
          if (idx >= 0) add_item(ACT_FREE, frame_address(idx));
          else add_item(ACT_ALLOC, ADDR_W'($urandom));
        end else begin
          add_item(ACT_ALLOC, ADDR_W'($urandom));
        end
        made++;
      end
    end
  endtask

  // wait until every queued item has been taken and answered
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // apb write of the frame limit register
  task automatic write_limit(logic [LIMIT_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({REG_FRAME_LIMIT, 2'b00});
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_reg = val;
    gen_lim   = 32'(val);
    @(negedge clk);
  endtask

  // driver: presents queued items, holds start while busy
  always @(posedge clk) begin : drive_items
    frame_result_t exp_res;
    bit            slot_free;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      slot_free = !start;
      if (start && !busy) begin
        exp_res = step_allocator(drv_item.action, drv_item.frame_addr);
        expected_results.push_back(exp_res);
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
          start      <= 1'b0;
          action     <= 1'($urandom_range(0, 1));
          frame_addr <= ADDR_W'($urandom);
        end else if (pending_items.size() > 0) begin
          drv_item = pending_items.pop_front();
          start      <= 1'b1;
          action     <= drv_item.action;
          frame_addr <= drv_item.frame_addr;
          gap_left = pick_gap();
        end else begin
          start      <= 1'b0;
          action     <= 1'($urandom_range(0, 1));
          frame_addr <= ADDR_W'($urandom);
        end
      end
    end
  end

  // monitor: compares each result with the oldest prediction
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: addr %h failed %b count %0d",
                   granted_addr, failed, free_count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (granted_addr !== want.granted_addr || failed !== want.failed ||
            free_count !== want.free_count) begin
          if (errors < 10)
            $display({"mismatch: addr exp %h got %h, failed exp %b got %b, ",
                      "count exp %0d got %0d"},
                     want.granted_addr, granted_addr, want.failed, failed,
                     want.free_count, free_count);
          errors++;
        end
      end
    end
  end

  // stimulus phases
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // limit at reset value zero: every free rejected, list empty
    add_item(ACT_ALLOC, '0);
    add_item(ACT_FREE, '0);
    add_item(ACT_FREE, '1);
    add_item(ACT_ALLOC, '1);
    wait_idle();

    // single frame: frame 0 is allocatable, frame 1 out of range
    write_limit(LIMIT_W'(1));
    add_item(ACT_FREE, 24'h000FFF);
    add_item(ACT_FREE, 24'h001000);
    add_item(ACT_ALLOC, 24'h000000);
    add_item(ACT_ALLOC, 24'hFFFFFF);
    wait_idle();

    // full range: top frame, frame 0, lifo order, then empty
    write_limit(LIMIT_W'(FRAMES));
    add_item(ACT_FREE, 24'hFFFFFF);
    add_item(ACT_FREE, 24'h000000);
    add_item(ACT_FREE, 24'h800123);
    add_item(ACT_ALLOC, 24'h000000);
    add_item(ACT_ALLOC, 24'hFFFFFF);
    add_item(ACT_ALLOC, 24'h5A5A5A);
    add_item(ACT_ALLOC, 24'h000000);
    gen_random(300, 1'b0);
    wait_idle();

    // small limit: many rejects, frames reused often
    write_limit(LIMIT_W'($urandom_range(2, 64)));
    gen_random(200, 1'b0);
    wait_idle();

    // limit back to zero: frees rejected, allocates drain the list
    write_limit('0);
    gen_random(40, 1'b0);
    wait_idle();

    // limit above the frame count acts as the frame count
    write_limit('1);
    gen_random(200, 1'b0);
    wait_idle();

    write_limit(LIMIT_W'(FRAMES));
    gen_random(200, 1'b0);
    // drain the list, then double free so the count bottoms out at zero
    repeat (gen_stack.size() + 1) add_item(ACT_ALLOC, ADDR_W'($urandom));
    add_item(ACT_FREE, 24'h003000);
    add_item(ACT_FREE, 24'h003ABC);
    repeat (4) add_item(ACT_ALLOC, ADDR_W'($urandom));
    // run of frees with repeated frames
    repeat (64) add_item(ACT_FREE, frame_address($urandom_range(0, FRAMES - 1)));
    repeat (3) add_item(ACT_ALLOC, ADDR_W'($urandom));
    gen_random(60, 1'b1);
    wait_idle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/pffl_pkg.sv
hdl/pffl_ram.sv
hdl/pffl_ctrl.sv
hdl/pffl_dp.sv
hdl/page_frame_free_list_top.sv
dv/tb_page_frame_free_list_top.sv
